// ----- hw/rtl/sba_pkg.sv -----
// shared constants, codes and controller/datapath interface types of the slab and bump allocator
`default_nettype none

package sba_pkg;

  // region geometry
  localparam int MAX_SLABS    = 256;
  localparam int REGION_BITS  = 20;
  localparam int HEADER_BYTES = 16;
  localparam int ROUND_UNIT   = 16;

  // field and state widths
  localparam int IDX_W   = $clog2(MAX_SLABS);
  localparam int LINK_W  = IDX_W + 1;
  localparam int SIZE_W  = 13;
  localparam int COUNT_W = 9;
  localparam int OFFS_W  = REGION_BITS;
  localparam int AREA_W  = REGION_BITS + 1;
  localparam int QUOT_W  = IDX_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 20;

  // empty free stack marker
  localparam logic [LINK_W-1:0] NIL_SLAB = LINK_W'(MAX_SLABS);
  // largest slab size for which the whole stack of slabs always fits in the region
  localparam logic [SIZE_W-1:0] SLAB_FIT_MAX = SIZE_W'((1 << REGION_BITS) / MAX_SLABS);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLAB_SIZE     = 2'd0,
    CFG_SLAB_COUNT    = 2'd1,
    CFG_GENERAL_BYTES = 2'd2
  } cfg_idx_e;

  // item modes
  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_INIT   = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_OUT_RANGE  = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_ALREADY    = 3'd5
  } status_e;

  // result offset source
  typedef enum logic [1:0] {
    OSEL_ZERO = 2'd0,
    OSEL_BUMP = 2'd1,
    OSEL_MUL  = 2'd2
  } osel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    div_fit;
    logic    div_free;
    logic    nslabs_load;
    logic    area_load;
    logic    init;
    logic    take_fresh;
    logic    pop_rd;
    logic    pop_link;
    logic    push;
    logic    bump;
    logic    respond;
    status_e resp_status;
    osel_e   resp_sel;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       started;
    logic       s_big;
    logic       div_done;
    logic       size_eq;
    logic       head_nil;
    logic       fresh_lt_n;
    logic       bump_ok;
    logic       offs_out;
    logic       offs_in_slab;
    logic       rem_nz;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sba_div.sv -----
// iterative divider, two quotient bits per cycle, quotient known to fit in the index width
`default_nettype none

module sba_div import sba_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [AREA_W-1:0] dividend_i,
  input  wire logic [SIZE_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [QUOT_W-1:0]      quot_o,
  output logic                   rem_nz_o
);

  localparam int STEPS = QUOT_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [AREA_W-1:0] rem_q;
  logic [SIZE_W-1:0] div_q;
  logic [QUOT_W-1:0] quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [CNT_W:0]    sh_hi;
  logic [CNT_W:0]    sh_lo;
  logic [AREA_W-1:0] d_hi;
  logic [AREA_W-1:0] d_lo;
  logic [AREA_W-1:0] rem_mid;
  logic [AREA_W-1:0] rem_new;
  logic              bit_hi;
  logic              bit_lo;

  // two restoring steps per cycle, high bit first
  always_comb begin
    sh_hi   = {cnt_q, 1'b1};
    sh_lo   = {cnt_q, 1'b0};
    d_hi    = AREA_W'(div_q) << sh_hi;
    d_lo    = AREA_W'(div_q) << sh_lo;
    bit_hi  = rem_q >= d_hi;
    rem_mid = bit_hi ? rem_q - d_hi : rem_q;
    bit_lo  = rem_mid >= d_lo;
    rem_new = bit_lo ? rem_mid - d_lo : rem_mid;
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(STEPS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // partial remainder and quotient, quotient bits shifted in from the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_new;
      quot_q <= {quot_q[QUOT_W-3:0], bit_hi, bit_lo};
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sba_datapath.sv -----
// allocator datapath: configuration, allocator state, link memory, divider, multiplier and result registers
`default_nettype none

module sba_datapath import sba_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic [OFFS_W-1:0]    request_size_i,
  input  wire logic [OFFS_W-1:0]    block_offset_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic                      result_valid_o,
  output logic [2:0]                status_o,
  output logic [OFFS_W-1:0]         result_offset_o
);

  localparam int PROD_W = COUNT_W + SIZE_W;
  localparam logic [AREA_W:0] REGION_END = (AREA_W+1)'(1 << REGION_BITS);

  // configuration registers
  logic [SIZE_W-1:0]  slab_size_q;
  logic [COUNT_W-1:0] slab_count_q;
  logic [OFFS_W-1:0]  general_q;

  // latched item
  logic [1:0]         mode_q;
  logic [OFFS_W-1:0]  size_q;
  logic [OFFS_W-1:0]  offs_q;

  // allocator state
  logic               started_q;
  logic [LINK_W-1:0]  head_q;
  logic [COUNT_W-1:0] fresh_q;
  logic [AREA_W-1:0]  pos_q;
  logic [OFFS_W-1:0]  brem_q;

  // per-item working registers
  logic [COUNT_W-1:0] nslabs_q;
  logic [AREA_W-1:0]  area_q;
  logic [IDX_W-1:0]   idx_q;
  logic [LINK_W-1:0]  link_rd_q;

  // result registers
  logic               valid_q;
  status_e            status_q;
  logic [OFFS_W-1:0]  offset_q;

  // free stack links
  logic [LINK_W-1:0]  link_mem [MAX_SLABS];

  logic               div_done;
  logic [QUOT_W-1:0]  quot;
  logic               rem_nz;
  logic [AREA_W-1:0]  dividend;

  logic [COUNT_W-1:0] cap;
  logic               s_big;
  logic [COUNT_W-1:0] nslabs_d;
  logic [COUNT_W-1:0] mul_a;
  logic [PROD_W-1:0]  product;
  logic [AREA_W-1:0]  rsize;
  logic [AREA_W-1:0]  used;
  logic [AREA_W:0]    bump_end;
  logic [AREA_W-1:0]  bump_res;
  logic [OFFS_W-1:0]  brem_d;
  logic [AREA_W:0]    limit_sum;
  logic [OFFS_W-1:0]  brem_init;
  logic [LINK_W-1:0]  link_clamp;
  logic [OFFS_W-1:0]  offset_d;

  // shared divider for slab fit and slab index
  assign dividend = cmd_i.div_fit ? AREA_W'(1 << REGION_BITS) : AREA_W'(offs_q);

  sba_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_fit | cmd_i.div_free),
    .dividend_i (dividend),
    .divisor_i  (slab_size_q),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_nz_o   (rem_nz)
  );

  // effective slab count
  always_comb begin
    cap   = (slab_count_q > COUNT_W'(MAX_SLABS)) ? COUNT_W'(MAX_SLABS) : slab_count_q;
    s_big = slab_size_q > SLAB_FIT_MAX;
    if (slab_size_q == '0) begin
      nslabs_d = '0;
    end else if (s_big && (COUNT_W'(quot) < cap)) begin
      nslabs_d = COUNT_W'(quot);
    end else begin
      nslabs_d = cap;
    end
  end

  // shared multiplier: slab area or slab offset
  assign mul_a   = cmd_i.area_load ? nslabs_q : COUNT_W'(idx_q);
  assign product = PROD_W'(mul_a) * PROD_W'(slab_size_q);

  // bump arithmetic
  always_comb begin
    rsize     = (AREA_W'(size_q) + AREA_W'(ROUND_UNIT - 1)) & ~AREA_W'(ROUND_UNIT - 1);
    used      = rsize + AREA_W'(HEADER_BYTES);
    bump_end  = (AREA_W+1)'(pos_q) + (AREA_W+1)'(HEADER_BYTES) + (AREA_W+1)'(rsize);
    bump_res  = pos_q + AREA_W'(HEADER_BYTES);
    brem_d    = (AREA_W'(brem_q) >= used) ? OFFS_W'(AREA_W'(brem_q) - used) : '0;
    brem_init = (general_q > OFFS_W'(HEADER_BYTES)) ? general_q - OFFS_W'(HEADER_BYTES) : '0;
    limit_sum = (AREA_W+1)'(area_q) + (AREA_W+1)'(general_q);
    link_clamp = (link_rd_q > NIL_SLAB) ? NIL_SLAB : link_rd_q;
  end

  // status to controller
  always_comb begin
    sts_o.mode         = mode_q;
    sts_o.started      = started_q;
    sts_o.s_big        = s_big;
    sts_o.div_done     = div_done;
    sts_o.size_eq      = (nslabs_q != '0) && (size_q == OFFS_W'(slab_size_q));
    sts_o.head_nil     = head_q >= NIL_SLAB;
    sts_o.fresh_lt_n   = fresh_q < nslabs_q;
    sts_o.bump_ok      = (AREA_W'(brem_q) >= rsize) && (bump_end < REGION_END);
    sts_o.offs_out     = (AREA_W+1)'(offs_q) >= limit_sum;
    sts_o.offs_in_slab = AREA_W'(offs_q) < area_q;
    sts_o.rem_nz       = rem_nz;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slab_size_q  <= SIZE_W'(64);
      slab_count_q <= COUNT_W'(256);
      general_q    <= OFFS_W'(49152);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLAB_SIZE:     slab_size_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_SLAB_COUNT:    slab_count_q <= cfg_wdata_i[COUNT_W-1:0];
        CFG_GENERAL_BYTES: general_q    <= cfg_wdata_i[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // allocator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      head_q    <= NIL_SLAB;
      fresh_q   <= '0;
      pos_q     <= '0;
      brem_q    <= '0;
    end else begin
      if (cmd_i.init) begin
        started_q <= 1'b1;
        head_q    <= NIL_SLAB;
        fresh_q   <= '0;
        pos_q     <= area_q;
        brem_q    <= brem_init;
      end
      if (cmd_i.take_fresh) begin
        fresh_q <= fresh_q + 1'b1;
      end
      if (cmd_i.pop_link) begin
        head_q <= link_clamp;
      end
      if (cmd_i.push) begin
        head_q <= LINK_W'(quot);
      end
      if (cmd_i.bump) begin
        pos_q  <= pos_q + used;
        brem_q <= brem_d;
      end
    end
  end

  // item and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q <= mode_i;
      size_q <= request_size_i;
      offs_q <= block_offset_i;
    end
    if (cmd_i.nslabs_load) begin
      nslabs_q <= nslabs_d;
    end
    if (cmd_i.area_load) begin
      area_q <= AREA_W'(product);
    end
    if (cmd_i.take_fresh) begin
      idx_q <= fresh_q[IDX_W-1:0];
    end
    if (cmd_i.pop_rd) begin
      idx_q <= head_q[IDX_W-1:0];
    end
  end

  // link memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      link_mem[quot] <= head_q;
    end
    if (cmd_i.pop_rd) begin
      link_rd_q <= link_mem[head_q[IDX_W-1:0]];
    end
  end

  // result offset select
  always_comb begin
    case (cmd_i.resp_sel)
      OSEL_BUMP: offset_d = bump_res[OFFS_W-1:0];
      OSEL_MUL:  offset_d = product[OFFS_W-1:0];
      default:   offset_d = '0;
    endcase
  end

  // result transfer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.respond;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      status_q <= cmd_i.resp_status;
      offset_q <= offset_d;
    end
  end

  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign result_offset_o = offset_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sba_ctrl.sv -----
// allocator controller: sequences each item through sizing, decision and follow-up steps
`default_nettype none

module sba_ctrl import sba_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIT,
    S_FIT_WAIT,
    S_AREA,
    S_DECIDE,
    S_POP,
    S_MUL_OUT,
    S_FREE_WAIT
  } state_e;

  state_e state_q;
  state_e state_d;

  // next state and datapath commands
  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.resp_status = ST_OK;
    cmd_o.resp_sel    = OSEL_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_FIT;
        end
      end
      S_FIT: begin
        if (sts_i.s_big) begin
          cmd_o.div_fit = 1'b1;
          state_d       = S_FIT_WAIT;
        end else begin
          cmd_o.nslabs_load = 1'b1;
          state_d           = S_AREA;
        end
      end
      S_FIT_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.nslabs_load = 1'b1;
          state_d           = S_AREA;
        end
      end
      S_AREA: begin
        cmd_o.area_load = 1'b1;
        state_d         = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_IDLE;
        unique case (sts_i.mode)
          MODE_INIT: begin
            cmd_o.respond     = 1'b1;
            cmd_o.init        = !sts_i.started;
            cmd_o.resp_status = sts_i.started ? ST_ALREADY : ST_OK;
          end
          MODE_ALLOC: begin
            if (!sts_i.started) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_NOT_INIT;
            end else if (sts_i.size_eq && !sts_i.head_nil) begin
              cmd_o.pop_rd = 1'b1;
              state_d      = S_POP;
            end else if (sts_i.size_eq && sts_i.fresh_lt_n) begin
              cmd_o.take_fresh = 1'b1;
              state_d          = S_MUL_OUT;
            end else if (sts_i.bump_ok) begin
              cmd_o.bump     = 1'b1;
              cmd_o.respond  = 1'b1;
              cmd_o.resp_sel = OSEL_BUMP;
            end else begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_NO_SPACE;
            end
          end
          MODE_FREE: begin
            if (!sts_i.started) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_NOT_INIT;
            end else if (sts_i.offs_out) begin
              cmd_o.respond     = 1'b1;
              cmd_o.resp_status = ST_OUT_RANGE;
            end else if (sts_i.offs_in_slab) begin
              cmd_o.div_free = 1'b1;
              state_d        = S_FREE_WAIT;
            end else begin
              cmd_o.respond = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POP: begin
        cmd_o.pop_link = 1'b1;
        state_d        = S_MUL_OUT;
      end
      S_MUL_OUT: begin
        cmd_o.respond  = 1'b1;
        cmd_o.resp_sel = OSEL_MUL;
        state_d        = S_IDLE;
      end
      S_FREE_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.respond = 1'b1;
          if (sts_i.rem_nz) begin
            cmd_o.resp_status = ST_MISALIGNED;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

`default_nettype wire

// ----- hw/rtl/slab_and_bump_allocator_core.sv -----
// slab and bump allocator top level: controller and datapath
// items pass the fit, area and decide states; init, bump, refusals, general-area frees respond
// from decide; fresh slabs add the multiply state, popped slabs pop and multiply, slab-area frees
// (misaligned too) the index division; slab sizes above 4096 bytes add the fit division
// throughput: one item at a time; a new item may start in the cycle its result is strobed
// results are strobed for one cycle and cannot be stalled by the receiver
// reset clears state and restores register defaults at once; link memory is not cleared
`default_nettype none

module slab_and_bump_allocator_core import sba_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           mode_i,
  input  wire logic [OFFS_W-1:0]    request_size_i,
  input  wire logic [OFFS_W-1:0]    block_offset_i,
  output logic                      result_valid_o,
  output logic [2:0]                status_o,
  output logic [OFFS_W-1:0]         result_offset_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  sba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // datapath and result transfer
  sba_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .mode_i          (mode_i),
    .request_size_i  (request_size_i),
    .block_offset_i  (block_offset_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .result_offset_o (result_offset_o)
  );

endmodule

`default_nettype wire

// ----- verif/slab_and_bump_allocator_core_checker.sv -----
// checker for the slab and bump allocator: tracks config and transfers, predicts and compares results
`default_nettype none

module slab_and_bump_allocator_core_checker import sba_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                 start_i,
  input  wire logic                 busy_i,
  input  wire logic [1:0]           mode_i,
  input  wire logic [OFFS_W-1:0]    request_size_i,
  input  wire logic [OFFS_W-1:0]    block_offset_i,
  input  wire logic                 result_valid_i,
  input  wire logic [2:0]           status_i,
  input  wire logic [OFFS_W-1:0]    result_offset_i,
  output int unsigned               fail_count_o,
  output int unsigned               due_count_o
);

  localparam int unsigned REGION_SPAN = 1 << REGION_BITS;

  typedef struct packed {
    status_e             status;
    logic [OFFS_W-1:0]   offset;
  } reply_t;

  // shadow registers
  logic [SIZE_W-1:0]  slab_size_q    = SIZE_W'(64);
  logic [COUNT_W-1:0] slab_count_q   = COUNT_W'(256);
  logic [CFG_W-1:0]   general_q      = CFG_W'(49152);

  // shadow allocator state
  bit                 started_q      = 1'b0;
  logic [LINK_W-1:0]  link_q [MAX_SLABS];
  logic [LINK_W-1:0]  head_q         = NIL_SLAB;
  logic [LINK_W-1:0]  fresh_q        = '0;
  logic [AREA_W-1:0]  bump_pos_q     = '0;
  logic [OFFS_W-1:0]  bump_left_q    = '0;

  reply_t replies_due[$];

  // slabs that currently fit: bounded by count, stack depth and region size
  function automatic int unsigned live_slabs();
    int unsigned n;
    if (slab_size_q == '0) return 0;
    n = (slab_count_q > MAX_SLABS) ? MAX_SLABS : 32'(slab_count_q);
    if (n > REGION_SPAN / slab_size_q) n = REGION_SPAN / slab_size_q;
    return n;
  endfunction

  // works out the reply to one item and moves the shadow state along
  function automatic void predict_reply(input logic [1:0] op, input logic [OFFS_W-1:0] size,
                                        input logic [OFFS_W-1:0] offs, output bit has_reply,
                                        output reply_t r);
    int unsigned nslabs, area, rsize, used, idx;
    nslabs    = live_slabs();
    area      = nslabs * slab_size_q;
    has_reply = 1'b1;
    r.status  = ST_OK;
    r.offset  = '0;
    case (op)
      MODE_INIT: begin
        if (started_q) begin
          r.status = ST_ALREADY;
        end else begin
          started_q   = 1'b1;
          head_q      = NIL_SLAB;
          fresh_q     = '0;
          bump_pos_q  = AREA_W'(area);
          bump_left_q = (general_q > HEADER_BYTES) ? OFFS_W'(general_q - HEADER_BYTES) : '0;
        end
      end
      MODE_ALLOC: begin
        if (!started_q) begin
          r.status = ST_NOT_INIT;
        end else if (nslabs != 0 && size == slab_size_q && head_q < NIL_SLAB) begin
          // reuse the most recently freed slab
          idx      = 32'(head_q);
          head_q   = link_q[idx];
          if (head_q > NIL_SLAB) head_q = NIL_SLAB;
          r.offset = OFFS_W'(idx * slab_size_q);
        end else if (nslabs != 0 && size == slab_size_q && fresh_q < nslabs) begin
          idx      = 32'(fresh_q);
          fresh_q  = LINK_W'(idx + 1);
          r.offset = OFFS_W'(idx * slab_size_q);
        end else begin
          // bump allocation behind a header, rounded to the unit
          rsize = (size + ROUND_UNIT - 1) & ~(ROUND_UNIT - 1);
          if (bump_left_q >= rsize && bump_pos_q + HEADER_BYTES + rsize < REGION_SPAN) begin
            used        = rsize + HEADER_BYTES;
            r.offset    = OFFS_W'(bump_pos_q + HEADER_BYTES);
            bump_pos_q  = AREA_W'(bump_pos_q + used);
            bump_left_q = (bump_left_q >= used) ? OFFS_W'(bump_left_q - used) : '0;
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
      end
      MODE_FREE: begin
        if (!started_q) begin
          r.status = ST_NOT_INIT;
        end else if (offs >= area + general_q) begin
          r.status = ST_OUT_RANGE;
        end else if (offs < area) begin
          if (offs % slab_size_q != 0) begin
            r.status = ST_MISALIGNED;
          end else begin
            idx         = 32'(offs / slab_size_q);
            link_q[idx] = head_q;
            head_q      = LINK_W'(idx);
          end
        end
      end
      default: begin
        has_reply = 1'b0;
      end
    endcase
  endfunction

  // compare strobed results, then record new transfers and register writes
  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want, got;
    bit     has_reply;
    if (!rst_ni) begin
      slab_size_q  = SIZE_W'(64);
      slab_count_q = COUNT_W'(256);
      general_q    = CFG_W'(49152);
      started_q    = 1'b0;
      head_q       = NIL_SLAB;
      fresh_q      = '0;
      bump_pos_q   = '0;
      bump_left_q  = '0;
      replies_due.delete();
    end else begin
      if (result_valid_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing outstanding: expected none, %s 0x%05h",
                   $time, $sformatf("got status %0d offset", status_i), result_offset_i);
          fail_count_o++;
        end else begin
          want = replies_due.pop_front();
          if (status_i !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status_i);
            fail_count_o++;
          end
          if (result_offset_i !== want.offset) begin
            $display("%0t: offset mismatch: expected 0x%05h, got 0x%05h",
                     $time, want.offset, result_offset_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_reply(mode_i, request_size_i, block_offset_i, has_reply, got);
        if (has_reply) replies_due.push_back(got);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLAB_SIZE:     slab_size_q  = cfg_wdata_i[SIZE_W-1:0];
          CFG_SLAB_COUNT:    slab_count_q = cfg_wdata_i[COUNT_W-1:0];
          CFG_GENERAL_BYTES: general_q    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    due_count_o = replies_due.size();
  end

endmodule

`default_nettype wire

// ----- verif/slab_and_bump_allocator_core_tb.sv -----
// testbench top for the slab and bump allocator: clock, reset, stimulus and verdict
`default_nettype none

module slab_and_bump_allocator_core_tb import sba_pkg::*;;

  localparam logic [1:0]           MODE_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned REGION_SPAN  = 1 << REGION_BITS;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LIMIT_TIME   = 5000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 start;
  logic                 busy;
  logic [1:0]           mode;
  logic [OFFS_W-1:0]    request_size;
  logic [OFFS_W-1:0]    block_offset;
  logic                 result_valid;
  logic [2:0]           status;
  logic [OFFS_W-1:0]    result_offset;
  int unsigned          fail_count;
  int unsigned          due_count;

  // current register settings, used to aim the stimulus
  int unsigned slab_sz   = 64;
  int unsigned slab_cnt  = 256;
  int unsigned gen_bytes = 49152;
  int unsigned calm_left = 0;

  slab_and_bump_allocator_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode),
    .request_size_i  (request_size),
    .block_offset_i  (block_offset),
    .result_valid_o  (result_valid),
    .status_o        (status),
    .result_offset_o (result_offset)
  );

  slab_and_bump_allocator_core_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .start_i         (start),
    .busy_i          (busy),
    .mode_i          (mode),
    .request_size_i  (request_size),
    .block_offset_i  (block_offset),
    .result_valid_i  (result_valid),
    .status_i        (status),
    .result_offset_i (result_offset),
    .fail_count_o    (fail_count),
    .due_count_o     (due_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #(LIMIT_TIME);
    $display("slab_and_bump_allocator_core_tb: done, errors");
    $finish;
  end

  // slab area under the current settings
  function automatic int unsigned slab_area_now();
    int unsigned n;
    if (slab_sz == 0) return 0;
    n = (slab_cnt > MAX_SLABS) ? MAX_SLABS : slab_cnt;
    if (n > REGION_SPAN / slab_sz) n = REGION_SPAN / slab_sz;
    return n * slab_sz;
  endfunction

  // random gap after a transfer, with occasional stretches of back-to-back items
  task automatic pause_after_transfer();
    int unsigned r, gap;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) calm_left = $urandom_range(20, 60);
      else if (r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
    end
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) begin
        mode         = 2'($urandom_range(0, 3));
        request_size = OFFS_W'($urandom);
        block_offset = OFFS_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  // one item transfer; called at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [OFFS_W-1:0] size,
                           input logic [OFFS_W-1:0] offs);
    start        = 1'b1;
    mode         = op;
    request_size = size;
    block_offset = offs;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    pause_after_transfer();
  endtask

  // wait for the block to go quiet before touching registers
  task automatic settle();
    start = 1'b0;
    while (due_count != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      CFG_SLAB_SIZE:     slab_sz   = 32'(data[SIZE_W-1:0]);
      CFG_SLAB_COUNT:    slab_cnt  = 32'(data[COUNT_W-1:0]);
      CFG_GENERAL_BYTES: gen_bytes = 32'(data);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // all three registers, upper data bits of the narrow ones filled with junk
  task automatic write_all(input int unsigned sz, input int unsigned cnt, input int unsigned gen);
    logic [CFG_W-1:0] data;
    data = CFG_W'($urandom);
    data[SIZE_W-1:0] = SIZE_W'(sz);
    write_reg(CFG_SLAB_SIZE, data);
    data = CFG_W'($urandom);
    data[COUNT_W-1:0] = COUNT_W'(cnt);
    write_reg(CFG_SLAB_COUNT, data);
    write_reg(CFG_GENERAL_BYTES, CFG_W'(gen));
  endtask

  // register settings per phase: extremes first, then random
  task automatic reconfigure(input int unsigned phase);
    int unsigned r, sz, cnt, gen;
    settle();
    case (phase)
      0: write_all(16, 1, 32);
      1: write_all(4096, 256, 786432);
      2: write_all(0, 0, 20'hFFFFF);
      3: write_all(8191, 511, $urandom_range(32, 786432));
      default: begin
        r = $urandom_range(0, 99);
        if (r < 60) sz = $urandom_range(16, 512);
        else if (r < 85) sz = $urandom_range(16, 4096);
        else sz = $urandom_range(0, 8191);
        cnt = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 256) : $urandom_range(0, 511);
        gen = ($urandom_range(0, 99) < 70) ? $urandom_range(32, 786432)
                                           : $urandom_range(0, 20'hFFFFF);
        write_all(sz, cnt, gen);
      end
    endcase
  endtask

  // one random item; allocations and frees, often slab-sized or slab-aligned, plus some inits and unknown modes
  task automatic random_item(output bit counted);
    int unsigned r, area;
    logic [OFFS_W-1:0] size, offs;
    r       = $urandom_range(0, 99);
    size    = OFFS_W'($urandom);
    offs    = OFFS_W'($urandom);
    area    = slab_area_now();
    counted = 1'b1;
    if (r < 3) begin
      counted = 1'b0;
      send_item(MODE_UNUSED, size, offs);
    end else if (r < 6) begin
      send_item(MODE_INIT, size, offs);
    end else if (r < 55) begin
      r = $urandom_range(0, 99);
      if (r < 45) size = OFFS_W'(slab_sz);
      else if (r < 80) size = OFFS_W'($urandom_range(1, 256));
      else if (r < 93) size = OFFS_W'($urandom_range(257, 4096));
      else if (r < 97) size = OFFS_W'($urandom_range(1, 786432));
      else size = OFFS_W'($urandom_range(0, 20'hFFFFF));
      send_item(MODE_ALLOC, size, offs);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 55 && slab_sz != 0 && area >= slab_sz)
        offs = OFFS_W'($urandom_range(0, area / slab_sz - 1) * slab_sz);
      else if (r < 70 && area != 0)
        offs = OFFS_W'($urandom_range(0, area - 1));
      else if (r < 85)
        offs = OFFS_W'(area + $urandom_range(0, gen_bytes));
      else if (r < 95)
        offs = OFFS_W'(area + gen_bytes + $urandom_range(0, 3));
      send_item(MODE_FREE, size, offs);
    end
  endtask

  // stimulus and verdict
  initial begin
    int unsigned done, chunk, phase;
    bit counted;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_SLAB_SIZE;
    cfg_wdata    = '0;
    start        = 1'b0;
    mode         = MODE_INIT;
    request_size = '0;
    block_offset = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // before initialization: requests are refused, unknown mode is dropped
    send_item(MODE_ALLOC, 64, 0);
    send_item(MODE_FREE, 0, 0);
    send_item(MODE_UNUSED, 20'hFFFFF, 20'hFFFFF);
    settle();
    write_reg(CFG_IDX_SPARE, '1);
    // general area reaches past the region so the region bound limits bumps
    write_all(64, 256, 20'hFFFFF);

    // start once, repeat refused
    send_item(MODE_INIT, 0, 0);
    send_item(MODE_INIT, 20'hFFFFF, 20'hFFFFF);
    // fresh slabs, frees, then pops in stack order
    send_item(MODE_ALLOC, 64, 0);
    send_item(MODE_ALLOC, 64, 0);
    send_item(MODE_FREE, 0, 64);
    send_item(MODE_FREE, 0, 0);
    send_item(MODE_ALLOC, 64, 0);
    send_item(MODE_ALLOC, 64, 0);
    // bump sizes around the rounding unit
    send_item(MODE_ALLOC, 1, 0);
    send_item(MODE_ALLOC, 16, 0);
    send_item(MODE_ALLOC, 17, 0);
    send_item(MODE_ALLOC, 0, 0);
    // room left but block would cross the region end, then too big outright
    send_item(MODE_ALLOC, 1032176, 0);
    send_item(MODE_ALLOC, 20'hFFFFF, 0);
    // misaligned slab frees and a free in the general area
    send_item(MODE_FREE, 0, 65);
    send_item(MODE_FREE, 0, 16383);
    send_item(MODE_FREE, 0, 16384);
    // range edge of the general area
    settle();
    write_reg(CFG_GENERAL_BYTES, 786432);
    send_item(MODE_FREE, 0, 802815);
    send_item(MODE_FREE, 0, 802816);
    send_item(MODE_FREE, 0, 20'hFFFFF);
    send_item(MODE_UNUSED, 0, 0);

    // random phases, each under its own register settings
    done  = 0;
    phase = 0;
    while (done < RANDOM_ITEMS) begin
      reconfigure(phase);
      chunk = 0;
      while (chunk < PHASE_ITEMS && done < RANDOM_ITEMS) begin
        random_item(counted);
        if (counted) begin
          chunk++;
          done++;
        end
      end
      phase++;
    end

    // drain
    start = 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("slab_and_bump_allocator_core_tb: done, clean");
    end else begin
      $display("slab_and_bump_allocator_core_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/sba_pkg.sv
hw/rtl/sba_div.sv
hw/rtl/sba_datapath.sv
hw/rtl/sba_ctrl.sv
hw/rtl/slab_and_bump_allocator_core.sv
verif/slab_and_bump_allocator_core_checker.sv
verif/slab_and_bump_allocator_core_tb.sv
